@@ rtl/rtlg_pkg.sv @@
// ----------------------------------------------------------------------------
// rtlg_pkg: shared types and constants for the tree level growth core
// Command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rtlg_pkg;

   localparam logic FUNC_RESTART = 1'b0;
   localparam logic FUNC_GROW    = 1'b1;

   localparam logic REG_CHILDREN_MIN = 1'b0;
   localparam logic REG_CHILDREN_MAX = 1'b1;

   // width of the random words, one modulo step per bit
   localparam int RAND_WIDTH = 32;

   typedef struct packed {
      logic start;
      logic restart;
      logic mod_step;
      logic scan_issue;
      logic scan_check;
      logic rd_chosen;
      logic rd_next;
      logic commit_a;
      logic commit_b;
      logic rsp_load;
   } ctrl_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic ovf;
   } stat_type;

endpackage

@@ rtl/random_tree_level_growth_core.sv @@
// ----------------------------------------------------------------------------
// random_tree_level_growth_core: level histogram of a randomly growing tree
//
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_stall  | func, pick_random, count_random
// rsp     | out | rsp_valid/rsp_stall  | level_total, weight_total,
//         |     |                      | chosen_level, overflow
// csr     | in  | csr_write_enable     | csr_index, csr_write_data
//
// Restart resets the totals and level 0, then loads the result. Grow runs the
// bit-serial modulo, scans the levels up to the chosen one, then reads, commits
// and loads the result; a refused grow skips the commit.
// Reset sets total and level count and writes level 0 to 1.
// req_stall is high while an item is in work; a stalled result keeps the
// following item in the result stage until its transfer.
// ----------------------------------------------------------------------------
module random_tree_level_growth_core #(
   parameter int MAX_LEVELS  = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_pick_random,
   input  logic [31:0] req_count_random,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_level_total,
   output logic [31:0] rsp_weight_total,
   output logic [9:0]  rsp_chosen_level,
   output logic        rsp_overflow
);
   import rtlg_pkg::*;

   ctrl_type   ctrl;
   stat_type   stat;
   logic [7:0] cmin_ff, cmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmin_ff <= 8'd1;
         cmax_ff <= 8'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CHILDREN_MIN: cmin_ff <= csr_write_data;
            REG_CHILDREN_MAX: cmax_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   rtlg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func (req_func),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .stat     (stat),
      .ctrl     (ctrl)
   );

   rtlg_dpath #(.MAX_LEVELS(MAX_LEVELS), .COUNT_WIDTH(COUNT_WIDTH)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .csr_children_min(cmin_ff),
      .csr_children_max(cmax_ff),
      .req_pick_random (req_pick_random),
      .req_count_random(req_count_random),
      .rsp_level_total (rsp_level_total),
      .rsp_weight_total(rsp_weight_total),
      .rsp_chosen_level(rsp_chosen_level),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

@@ rtl/rtlg_ram.sv @@
// ----------------------------------------------------------------------------
// rtlg_ram: generic single-port RAM with registered read
// One access per cycle; a write also reads the old word at that address.
// ----------------------------------------------------------------------------
module rtlg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rtlg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtlg_ctrl: sequencer for the tree level growth core
// Steps the restart, the modulo unit, the level scan, the commit and the result stage.
// ----------------------------------------------------------------------------
module rtlg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   input  rtlg_pkg::stat_type stat,
   output rtlg_pkg::ctrl_type ctrl
);
   import rtlg_pkg::*;

   localparam int CW = $clog2(RAND_WIDTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_RDN  = 3'd3;
   localparam logic [2:0] S_WRA  = 3'd4;
   localparam logic [2:0] S_WRB  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.start = 1'b1;
               if (req_func == FUNC_RESTART) begin
                  ctrl.restart = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  cnt_in   = '0;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            ctrl.mod_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CW'(RAND_WIDTH - 1)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl.scan_check = pend_ff;
            if (pend_ff && (stat.scan_hit || stat.scan_end)) begin
               ctrl.rd_next = 1'b1;
               state_in     = S_RDN;
            end else begin
               ctrl.scan_issue = 1'b1;
               pend_in         = 1'b1;
            end
         end
         S_RDN: begin
            ctrl.rd_chosen = 1'b1;
            state_in       = S_WRA;
         end
         // next level is written first, then the chosen level
         S_WRA: begin
            if (stat.ovf) begin
               state_in = S_OUT;
            end else begin
               ctrl.commit_b = 1'b1;
               state_in      = S_WRB;
            end
         end
         S_WRB: begin
            ctrl.commit_a = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/rtlg_dpath.sv @@
// ----------------------------------------------------------------------------
// rtlg_dpath: datapath of the tree level growth core
// Bit-serial modulo, level count RAM, running-sum scan and commit.
// ----------------------------------------------------------------------------
module rtlg_dpath #(
   parameter int MAX_LEVELS  = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  rtlg_pkg::ctrl_type ctrl,
   output rtlg_pkg::stat_type stat,
   input  logic [7:0]         csr_children_min,
   input  logic [7:0]         csr_children_max,
   input  logic [31:0]        req_pick_random,
   input  logic [31:0]        req_count_random,
   output logic [10:0]        rsp_level_total,
   output logic [31:0]        rsp_weight_total,
   output logic [9:0]         rsp_chosen_level,
   output logic               rsp_overflow
);
   import rtlg_pkg::*;

   localparam int AW = $clog2(MAX_LEVELS);
   localparam int LW = $clog2(MAX_LEVELS + 1);
   localparam int W  = COUNT_WIDTH;

   logic [W-1:0]  weight_ff, weight_in;
   logic [LW-1:0] used_ff, used_in;
   logic [31:0]   pick_ff, pick_in;   // dividend shifts out, quotient ignored
   logic [W-1:0]  rem_ff, rem_in;
   logic [7:0]    crem_ff, crem_in;
   logic [7:0]    div_ff, div_in;
   logic [31:0]   crnd_ff, crnd_in;
   logic [8:0]    child_c;
   logic [W:0]    rtrial;
   logic [8:0]    ctrial;
   logic [W-1:0]  cum_ff, cum_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] chosen_ff, chosen_in;
   logic [W-1:0]  cnt_a_ff, cnt_a_in;
   logic          ovf_ff, ovf_in;
   logic [W-1:0]  cum_sum;
   logic          last_lvl;
   logic [W:0]    wsum;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [W-1:0]  ram_wdata, ram_rdata;

   logic [10:0]   lt_ff;
   logic [31:0]   wt_ff;
   logic [9:0]    cl_ff;
   logic          of_ff;

   rtlg_ram #(.WIDTH(W), .DEPTH(MAX_LEVELS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign child_c = (div_ff == 8'd0) ? {1'b0, csr_children_min}
                                     : {1'b0, csr_children_min} + {1'b0, crem_ff};
   assign rtrial  = {rem_ff, pick_ff[31]} - {1'b0, weight_ff};
   assign ctrial  = {crem_ff, crnd_ff[31]} - {1'b0, div_ff};
   assign cum_sum = cum_ff + ram_rdata;
   assign last_lvl = (LW'(chosen_ff) + 1'b1 == used_ff);
   assign wsum    = {1'b0, weight_ff} + W'(child_c) + 1'b1;

   assign stat.scan_hit    = cum_sum > rem_ff;
   assign stat.scan_end    = (LW'(idx_ff) + 1'b1 >= used_ff);
   assign stat.ovf         = ovf_ff;

   always_comb begin
      weight_in = weight_ff;
      used_in   = used_ff;
      pick_in   = pick_ff;
      rem_in    = rem_ff;
      crem_in   = crem_ff;
      div_in    = div_ff;
      crnd_in   = crnd_ff;
      cum_in    = cum_ff;
      idx_in    = idx_ff;
      chosen_in = chosen_ff;
      cnt_a_in  = cnt_a_ff;
      ovf_in    = ovf_ff;
      ram_we    = 1'b0;
      ram_addr  = idx_ff;
      ram_wdata = ram_rdata;

      if (ctrl.start) begin
         pick_in   = req_pick_random;
         crnd_in   = req_count_random;
         rem_in    = '0;
         crem_in   = '0;
         div_in    = (csr_children_max > csr_children_min) ?
                     csr_children_max - csr_children_min : 8'd0;
         cum_in    = '0;
         idx_in    = '0;
         chosen_in = '0;
         ovf_in    = 1'b0;
      end
      if (ctrl.restart) begin
         ram_we    = 1'b1;
         ram_addr  = '0;
         ram_wdata = W'(1);
         weight_in = W'(1);
         used_in   = LW'(1);
      end
      if (ctrl.mod_step) begin
         pick_in = {pick_ff[30:0], 1'b0};
         rem_in  = rtrial[W] ? {rem_ff[W-2:0], pick_ff[31]} : rtrial[W-1:0];
         if (div_ff != 8'd0) begin
            crnd_in = {crnd_ff[30:0], 1'b0};
            crem_in = ctrial[8] ? {crem_ff[6:0], crnd_ff[31]} : ctrial[7:0];
         end
         if (rem_ff[W-1]) begin
            rem_in = {rem_ff[W-2:0], pick_ff[31]} - weight_ff;
         end
      end
      if (ctrl.scan_check) begin
         cum_in    = cum_sum;
         chosen_in = idx_ff;
         if (!stat.scan_hit && !stat.scan_end) begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (ctrl.scan_issue) begin
         ram_addr = ctrl.scan_check ? idx_in : idx_ff;
      end
      if (ctrl.rd_next) begin
         ram_addr = chosen_in;
      end
      if (ctrl.rd_chosen) begin
         cnt_a_in = ram_rdata + 1'b1;
         ram_addr = chosen_ff + 1'b1;
         ovf_in   = (last_lvl && used_ff >= LW'(MAX_LEVELS)) || wsum[W];
      end
      if (ctrl.commit_a) begin
         ram_we    = 1'b1;
         ram_addr  = chosen_ff;
         ram_wdata = cnt_a_ff;
      end
      if (ctrl.commit_b) begin
         ram_we    = 1'b1;
         ram_addr  = chosen_ff + 1'b1;
         ram_wdata = last_lvl ? W'(child_c) : ram_rdata + W'(child_c);
         weight_in = wsum[W-1:0];
         if (last_lvl) begin
            used_in = used_ff + 1'b1;
         end
      end
      // level 0 holds 1 out of reset
      if (reset) begin
         ram_we    = 1'b1;
         ram_addr  = '0;
         ram_wdata = W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= W'(1);
         used_ff   <= LW'(1);
      end else begin
         weight_ff <= weight_in;
         used_ff   <= used_in;
      end
      pick_ff   <= pick_in;
      rem_ff    <= rem_in;
      crem_ff   <= crem_in;
      div_ff    <= div_in;
      crnd_ff   <= crnd_in;
      cum_ff    <= cum_in;
      idx_ff    <= idx_in;
      chosen_ff <= chosen_in;
      cnt_a_ff  <= cnt_a_in;
      ovf_ff    <= ovf_in;
      if (ctrl.rsp_load) begin
         lt_ff <= 11'(used_ff);
         wt_ff <= 32'(weight_ff);
         cl_ff <= 10'(chosen_ff);
         of_ff <= ovf_ff;
      end
   end

   assign rsp_level_total  = lt_ff;
   assign rsp_weight_total = wt_ff;
   assign rsp_chosen_level = cl_ff;
   assign rsp_overflow     = of_ff;

endmodule
